@@ rtl/wmm_pkg.sv @@
`default_nettype none
package wmm_pkg;
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_ROWF   = 2'd1,
    OP_COLF   = 2'd2,
    OP_RESULT = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       clear;  // first term of a sum
    logic       odd;    // plain product term
    logic       emit;   // final term: result is registered out after stage 3
    logic       last;
    logic [2:0] i;
    logic [2:0] j;
    logic [2:0] k;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/wmm_datapath.sv @@
`default_nettype none
module wmm_datapath
  import wmm_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_a_i,
  input  wire logic        load_b_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [2:0]  col_index_i,
  input  wire logic [15:0] element_value_i,
  input  wire cmd_t        cmd_i,
  output logic             valid_o,
  output logic [2:0]       out_row_o,
  output logic [2:0]       out_col_o,
  output logic [31:0]      product_value_o,
  output logic             last_o
);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = $clog2(MAX_DIM);

  logic [ELEM_BITS-1:0] store_a [MAX_DIM*MAX_DIM];
  logic [ELEM_BITS-1:0] store_b [MAX_DIM*MAX_DIM];
  logic [31:0] row_factors_q [MAX_DIM];
  logic [31:0] col_factors_q [MAX_DIM];

  logic [ELEM_BITS-1:0] a0_q, a1_q, b0_q, b1_q;
  cmd_t s1_q, s2_q, s3_q;
  logic [31:0] x_q, y_q, prod_q, acc_q, acc_d, base;
  logic [31:0] wa;

  function automatic logic [31:0] sx(input logic [ELEM_BITS-1:0] v);
    return 32'(signed'(v));
  endfunction

  function automatic logic [AW-1:0] adr(input logic [2:0] r, input logic [2:0] c);
    return AW'(r[IW-1:0]) * AW'(MAX_DIM) + AW'(c[IW-1:0]);
  endfunction

  assign wa = 32'(signed'(element_value_i));

  // Stage 0: store writes and two reads per store.
  logic [2:0] k1;
  assign k1 = cmd_i.k + 3'd1;
  always_ff @(posedge clk_i) begin
    if (load_a_i && (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM)) begin
      store_a[adr(row_index_i, col_index_i)] <= wa[ELEM_BITS-1:0];
    end
    if (load_b_i && (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM)) begin
      store_b[adr(row_index_i, col_index_i)] <= wa[ELEM_BITS-1:0];
    end
    a0_q <= store_a[adr(cmd_i.i, cmd_i.k)];
    a1_q <= store_a[adr(cmd_i.i, cmd_i.odd ? cmd_i.k : k1)];
    b0_q <= store_b[adr(cmd_i.k, cmd_i.j)];
    b1_q <= store_b[adr(cmd_i.odd ? cmd_i.k : k1, cmd_i.j)];
  end

  // Stage 1: operand forming. Stage 2: multiply. Stage 3: accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= cmd_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (s1_q.op)
      OP_ROWF: begin
        x_q <= sx(a0_q);
        y_q <= sx(a1_q);
      end
      OP_COLF: begin
        x_q <= sx(b0_q);
        y_q <= sx(b1_q);
      end
      default: begin
        if (s1_q.odd) begin
          x_q <= sx(a0_q);
          y_q <= sx(b0_q);
        end else begin
          x_q <= sx(a0_q) + sx(b1_q);
          y_q <= sx(a1_q) + sx(b0_q);
        end
      end
    endcase
    prod_q <= x_q * y_q;
  end

  // A plain product that opens a sum means an inner size of one: there are no
  // pairs, so both factors are zero and the stored ones are not used.
  always_comb begin
    base = 32'd0;
    if (s3_q.op == OP_RESULT && !s3_q.odd) begin
      base = 32'd0 - (row_factors_q[s3_q.i[IW-1:0]] + col_factors_q[s3_q.j[IW-1:0]]);
    end
    acc_d = (s3_q.clear ? base : acc_q) + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < MAX_DIM; n++) begin
        row_factors_q[n] <= '0;
        col_factors_q[n] <= '0;
      end
      acc_q   <= '0;
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      out_row_o <= '0;
      out_col_o <= '0;
      product_value_o <= '0;
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      if (s3_q.op != OP_NONE) begin
        acc_q <= acc_d;
        if (s3_q.emit) begin
          case (s3_q.op)
            OP_ROWF: row_factors_q[s3_q.i[IW-1:0]] <= acc_d;
            OP_COLF: col_factors_q[s3_q.j[IW-1:0]] <= acc_d;
            default: begin
              valid_o <= 1'b1;
              last_o  <= s3_q.last;
              out_row_o <= s3_q.i;
              out_col_o <= s3_q.j;
              product_value_o <= acc_d;
            end
          endcase
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/wmm_controller.sv @@
`default_nettype none
module wmm_controller
  import wmm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       go_i,
  input  wire logic [3:0] rows_a_i,
  input  wire logic [3:0] inner_i,
  input  wire logic [3:0] cols_b_i,
  output logic            busy_o,
  output cmd_t            cmd_o
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROWF  = 3'd1;
  localparam logic [2:0] ST_COLF  = 3'd2;
  localparam logic [2:0] ST_RES   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] i_q, i_d, j_q, j_d, k_q, k_d, dr_q, dr_d;
  logic [3:0] ra, n, cb;
  logic [2:0] ilast, jlast, pairs_last;
  logic       has_pairs, odd_n, k_odd, k_end;

  function automatic logic [3:0] clampd(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (32'(v) > MAX_DIM) return 4'(MAX_DIM);
    return v;
  endfunction

  assign ra = clampd(rows_a_i);
  assign n  = clampd(inner_i);
  assign cb = clampd(cols_b_i);
  assign ilast = 3'(ra - 4'd1);
  assign jlast = 3'(cb - 4'd1);
  assign has_pairs = n > 4'd1;
  assign odd_n = n[0];
  assign pairs_last = 3'((n & 4'b1110) - 4'd2);
  // Result term k: pairs step by two, the odd tail sits at n-1.
  assign k_odd = odd_n && (k_q == 3'(n - 4'd1));
  assign k_end = k_odd || (!odd_n && k_q == pairs_last);

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q; dr_d = dr_q;
    cmd_o = '0;
    cmd_o.i = i_q; cmd_o.j = j_q; cmd_o.k = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          i_d = '0; j_d = '0; k_d = '0;
          state_d = has_pairs ? ST_ROWF : ST_RES;
        end
      end
      ST_ROWF: begin
        cmd_o.op = OP_ROWF;
        cmd_o.clear = (k_q == 3'd0);
        cmd_o.emit = (k_q == pairs_last);
        if (k_q == pairs_last) begin
          k_d = '0;
          if (i_q == ilast) begin
            i_d = '0;
            state_d = ST_COLF;
          end else begin
            i_d = i_q + 3'd1;
          end
        end else begin
          k_d = k_q + 3'd2;
        end
      end
      ST_COLF: begin
        cmd_o.op = OP_COLF;
        cmd_o.clear = (k_q == 3'd0);
        cmd_o.emit = (k_q == pairs_last);
        if (k_q == pairs_last) begin
          k_d = '0;
          if (j_q == jlast) begin
            j_d = '0;
            dr_d = 3'd3;
            state_d = ST_DRAIN;
          end else begin
            j_d = j_q + 3'd1;
          end
        end else begin
          k_d = k_q + 3'd2;
        end
      end
      ST_DRAIN: begin
        // Factors must be written back before the result pass reads them.
        dr_d = dr_q - 3'd1;
        if (dr_q == 3'd0) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        cmd_o.op = OP_RESULT;
        cmd_o.clear = (k_q == 3'd0);
        cmd_o.odd = k_odd;
        cmd_o.emit = k_end;
        cmd_o.last = k_end && i_q == ilast && j_q == jlast;
        if (k_end) begin
          k_d = '0;
          if (j_q == jlast) begin
            j_d = '0;
            if (i_q == ilast) begin
              dr_d = 3'd3;
              state_d = ST_IDLE;
            end else begin
              i_d = i_q + 3'd1;
            end
          end else begin
            j_d = j_q + 3'd1;
          end
        end else begin
          k_d = k_q + 3'd2;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE && dr_q != 3'd0) begin
      dr_d = dr_q - 3'd1;
    end
  end

  assign busy_o = (state_q != ST_IDLE) || (dr_q != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0; j_q <= '0; k_q <= '0; dr_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; dr_q <= dr_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/winograd_matrix_multiply_unit.sv @@
// Loads (func 0 and 1) are taken only while busy is low, and busy stays low.
// A start runs rows_a*P + cols_b*P factor terms (P = inner_size/2), a drain,
// then one term per cycle of each result (ceil(inner_size/2) terms); busy stays high
// past the last term while the drain count runs down, and falls in the cycle that
// carries the last result. Results leave via s1, s2, s3 and the output register.
// The receiver cannot stall; each result strobe lasts one cycle.
// Asynchronous active-low reset clears sizes to 8, the factors and all control state.
`default_nettype none
module winograd_matrix_multiply_unit
  import wmm_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [2:0]  col_index_i,
  input  wire logic [15:0] element_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  output logic             result_valid_o,
  output logic [2:0]       out_row_o,
  output logic [2:0]       out_col_o,
  output logic [31:0]      product_value_o,
  output logic             last_o
);
  logic [3:0] rows_a_q, inner_q, cols_b_q;
  logic acc;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= 4'd8; inner_q <= 4'd8; cols_b_q <= 4'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS_A: rows_a_q <= cfg_data_i;
        REG_INNER:  inner_q  <= cfg_data_i;
        REG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wmm_controller #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i, .rst_ni,
    .go_i(acc && func_i == FUNC_START),
    .rows_a_i(rows_a_q), .inner_i(inner_q), .cols_b_i(cols_b_q),
    .busy_o(busy), .cmd_o(cmd)
  );

  wmm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk_i, .rst_ni,
    .load_a_i(acc && func_i == FUNC_LOAD_A),
    .load_b_i(acc && func_i == FUNC_LOAD_B),
    .row_index_i, .col_index_i, .element_value_i,
    .cmd_i(cmd),
    .valid_o(result_valid_o), .out_row_o, .out_col_o, .product_value_o, .last_o
  );

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result while idle");
  a_last_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !result_valid_o) else $error("result after last");
endmodule
`default_nettype wire
